// File: hw/rtl/nci_pkg.sv
package nci_pkg;

    // Default build values
    localparam int MAX_CELLS_DEF = 256;
    localparam int COORD_W_DEF   = 32;

    // Fixed field widths
    localparam int CELL_SIZE_W = 31;
    localparam int CELL_CNT_W  = 9;
    localparam int INDEX_W     = 24;
    localparam int CFG_IDX_W   = 3;

    // Candidate cells around the home cell: 3 layers of 9
    localparam int N_CAND = 27;
    localparam int CAND_W = 5;

    // Depth of the queue between the coordinate and emit sides
    localparam int FIFO_DEPTH = 4;

    // Register reset values
    localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RST = 31'd65536;
    localparam logic [CELL_CNT_W-1:0]  CELL_CNT_RST  = 9'd16;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_CELL_SIZE = 3'd3,
        REG_CELLS_X   = 3'd4,
        REG_CELLS_Y   = 3'd5,
        REG_CELLS_Z   = 3'd6
    } cfg_reg_t;

    // Step along one axis relative to the home cell
    typedef enum logic [1:0] {
        OFS_MINUS  = 2'd0,
        OFS_CENTRE = 2'd1,
        OFS_PLUS   = 2'd2
    } ofs_t;

    typedef struct packed {
        ofs_t dz;
        ofs_t dy;
        ofs_t dx;
    } cand_ofs_t;

    // Map a candidate number to its step on each axis, in emission order.
    // Layers: own z, lower z, upper z. Within a layer: centre, x-1, x-1/y-1,
    // x-1/y+1, x+1, x+1/y-1, x+1/y+1, y-1, y+1.
    function automatic cand_ofs_t cand_offsets(input logic [CAND_W-1:0] j);
        logic [CAND_W-1:0] k;
        cand_ofs_t         r;
        if (j >= 5'd18) begin
            r.dz = OFS_PLUS;
            k    = j - 5'd18;
        end else if (j >= 5'd9) begin
            r.dz = OFS_MINUS;
            k    = j - 5'd9;
        end else begin
            r.dz = OFS_CENTRE;
            k    = j;
        end
        case (k)
            5'd0: begin r.dx = OFS_CENTRE; r.dy = OFS_CENTRE; end
            5'd1: begin r.dx = OFS_MINUS;  r.dy = OFS_CENTRE; end
            5'd2: begin r.dx = OFS_MINUS;  r.dy = OFS_MINUS;  end
            5'd3: begin r.dx = OFS_MINUS;  r.dy = OFS_PLUS;   end
            5'd4: begin r.dx = OFS_PLUS;   r.dy = OFS_CENTRE; end
            5'd5: begin r.dx = OFS_PLUS;   r.dy = OFS_MINUS;  end
            5'd6: begin r.dx = OFS_PLUS;   r.dy = OFS_PLUS;   end
            5'd7: begin r.dx = OFS_CENTRE; r.dy = OFS_MINUS;  end
            5'd8: begin r.dx = OFS_CENTRE; r.dy = OFS_PLUS;   end
            default: begin r.dx = OFS_CENTRE; r.dy = OFS_CENTRE; end
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/nci_fifo.sv
module nci_fifo #(
    parameter int WIDTH = 24,
    parameter int DEPTH = nci_pkg::FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import nci_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] mem_reg;
    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: hw/rtl/nci_front.sv
module nci_front #(
    parameter int COORD_WIDTH        = nci_pkg::COORD_W_DEF,
    parameter int MAX_CELLS_PER_AXIS = nci_pkg::MAX_CELLS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [2:0][COORD_WIDTH-1:0]                  pos,
    input  logic [2:0][COORD_WIDTH-1:0]                  origin,
    input  logic [nci_pkg::CELL_SIZE_W-1:0]              cell_size,
    input  logic [2:0][$clog2(MAX_CELLS_PER_AXIS)-1:0]   lim,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [2:0][$clog2(MAX_CELLS_PER_AXIS)-1:0]   coord
);
    import nci_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int CW   = $clog2(MAX_CELLS_PER_AXIS);
    localparam int DW   = (W > CELL_SIZE_W + CW) ? W : CELL_SIZE_W + CW;
    localparam int NSTG = CW + 1;
    localparam int LAST = NSTG - 1;

    logic [NSTG-1:0]                 vld_reg;
    logic [NSTG-1:0][2:0][DW-1:0]    rem_reg, rem_next;
    logic [NSTG-1:0][2:0][CW-1:0]    q_reg, q_next;
    logic [NSTG-1:0][2:0]            zero_reg, zero_next;
    logic [NSTG-1:0][2:0]            sat_reg, sat_next;
    logic [2:0][W:0]                 diff;
    logic [CELL_SIZE_W-1:0]          cs_eff;
    logic                            en;

    // Whole pipe stalls only when its last stage cannot hand over
    assign en        = !(vld_reg[LAST] && !out_ready);
    assign in_ready  = en;
    assign out_valid = vld_reg[LAST];
    assign cs_eff    = (cell_size == '0) ? CELL_SIZE_W'(1) : cell_size;

    // Subtract origin, then one restoring quotient bit per stage
    always_comb begin
        logic [DW-1:0] dvs;
        dvs = '0;
        for (int a = 0; a < 3; a++) begin
            diff[a] = {pos[a][W-1], pos[a]} - {origin[a][W-1], origin[a]};
            rem_next[0][a]  = DW'(diff[a][W-1:0]);
            zero_next[0][a] = diff[a][W] || (diff[a] == '0);
            sat_next[0][a]  = 1'b0;
            q_next[0][a]    = '0;
            for (int s = 1; s < NSTG; s++) begin
                dvs             = DW'(cs_eff) << (CW - s);
                zero_next[s][a] = zero_reg[s-1][a];
                if (s == 1) begin
                    sat_next[s][a] = (rem_reg[0][a] >= (DW'(cs_eff) << CW));
                end else begin
                    sat_next[s][a] = sat_reg[s-1][a];
                end
                if (rem_reg[s-1][a] >= dvs) begin
                    rem_next[s][a] = rem_reg[s-1][a] - dvs;
                    q_next[s][a]   = q_reg[s-1][a] | (CW'(1) << (CW - s));
                end else begin
                    rem_next[s][a] = rem_reg[s-1][a];
                    q_next[s][a]   = q_reg[s-1][a];
                end
            end
        end
    end

    // Clamp quotient to the grid
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (zero_reg[LAST][a]) begin
                coord[a] = '0;
            end else if (sat_reg[LAST][a] || (q_reg[LAST][a] > lim[a])) begin
                coord[a] = lim[a];
            end else begin
                coord[a] = q_reg[LAST][a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            zero_reg <= zero_next;
            sat_reg  <= sat_next;
        end
    end

endmodule

// File: hw/rtl/nci_back.sv
module nci_back #(
    parameter int MAX_CELLS_PER_AXIS = nci_pkg::MAX_CELLS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [2:0][$clog2(MAX_CELLS_PER_AXIS)-1:0]   coord,
    input  logic [2:0][$clog2(MAX_CELLS_PER_AXIS)-1:0]   lim,
    input  logic [$clog2(MAX_CELLS_PER_AXIS+1)-1:0]      nx,
    input  logic [nci_pkg::INDEX_W-1:0]                  nxy,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [nci_pkg::INDEX_W-1:0]                  m_tdata,
    output logic                                         m_tlast
);
    import nci_pkg::*;

    localparam int CW = $clog2(MAX_CELLS_PER_AXIS);

    logic [2:0][2:0]               ok;
    logic [N_CAND-1:0]             mask;
    logic [2:0][INDEX_W-1:0]       xv, yb, zb;
    logic [CW:0]                   yv, zv;
    cand_ofs_t                     ofs_j, sel;

    logic                          prep_valid_reg;
    logic [N_CAND-1:0]             prep_mask_reg;
    logic [2:0][INDEX_W-1:0]       prep_xv_reg, prep_yb_reg, prep_zb_reg;
    logic [N_CAND-1:0]             em_mask_reg;
    logic [2:0][INDEX_W-1:0]       em_xv_reg, em_yb_reg, em_zb_reg;
    logic                          m_tvalid_reg;
    logic [INDEX_W-1:0]            m_tdata_reg;
    logic                          m_tlast_reg;

    logic [CAND_W-1:0]             pick;
    logic [N_CAND-1:0]             mask_rest;
    logic [INDEX_W-1:0]            idx;
    logic                          out_free, fire, em_done, em_load, prep_take;

    // Prep: in-grid mask of the 27 candidates and per-step index bases
    always_comb begin
        yv = '0;
        zv = '0;
        for (int a = 0; a < 3; a++) begin
            ok[a][OFS_MINUS]  = (coord[a] != '0);
            ok[a][OFS_CENTRE] = 1'b1;
            ok[a][OFS_PLUS]   = (coord[a] != lim[a]);
        end
        for (int j = 0; j < N_CAND; j++) begin
            ofs_j   = cand_offsets(CAND_W'(j));
            mask[j] = ok[0][ofs_j.dx] & ok[1][ofs_j.dy] & ok[2][ofs_j.dz];
        end
        for (int o = 0; o < 3; o++) begin
            yv    = (CW+1)'(coord[1]) + (CW+1)'(o) - (CW+1)'(1);
            zv    = (CW+1)'(coord[2]) + (CW+1)'(o) - (CW+1)'(1);
            xv[o] = INDEX_W'(coord[0]) + INDEX_W'(o) - INDEX_W'(1);
            yb[o] = INDEX_W'(nx) * INDEX_W'(yv);
            zb[o] = nxy * INDEX_W'(zv);
        end
    end

    // Emit: take the lowest pending candidate each cycle the output register is free
    always_comb begin
        pick = '0;
        for (int j = N_CAND - 1; j >= 0; j--) begin
            if (em_mask_reg[j]) begin
                pick = CAND_W'(j);
            end
        end
        sel       = cand_offsets(pick);
        idx       = em_xv_reg[sel.dx] + em_yb_reg[sel.dy] + em_zb_reg[sel.dz];
        mask_rest = em_mask_reg & (em_mask_reg - N_CAND'(1));
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign fire      = out_free && (em_mask_reg != '0);
    assign em_done   = (em_mask_reg == '0) || (fire && (mask_rest == '0));
    assign em_load   = prep_valid_reg && em_done;
    assign in_ready  = !prep_valid_reg || em_load;
    assign prep_take = in_valid && in_ready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Control: prep slot, pending mask and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
            em_mask_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (prep_take) begin
                prep_valid_reg <= 1'b1;
            end else if (em_load) begin
                prep_valid_reg <= 1'b0;
            end
            if (em_load) begin
                em_mask_reg <= prep_mask_reg;
            end else if (fire) begin
                em_mask_reg <= mask_rest;
            end
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (prep_take) begin
            prep_mask_reg <= mask;
            prep_xv_reg   <= xv;
            prep_yb_reg   <= yb;
            prep_zb_reg   <= zb;
        end
        if (em_load) begin
            em_xv_reg <= prep_xv_reg;
            em_yb_reg <= prep_yb_reg;
            em_zb_reg <= prep_zb_reg;
        end
        if (fire) begin
            m_tdata_reg <= idx;
            m_tlast_reg <= (mask_rest == '0);
        end
    end

endmodule

// File: hw/rtl/neighbor_cell_index_gen.sv
// Path: an accepted position passes the divider pipeline, one quotient bit per stage, then the
// queue, the prep slot and the emit stage before its first cell index is sent.
// Throughput: one index per cycle while m_tready is high; a position gives as many indices as
// it has in-grid cells (1 to 27); the divider side takes one position per cycle unless stalled.
// Reset: aresetn, synchronous active low, empties all stages and loads register defaults
// (origin 0, cell_size 1.0, 16 cells per axis).
module neighbor_cell_index_gen #(
    parameter int MAX_CELLS_PER_AXIS = nci_pkg::MAX_CELLS_DEF,
    parameter int COORD_WIDTH        = nci_pkg::COORD_W_DEF
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    // pos_x, pos_y, pos_z from bit 0 up, zero padded to bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]              s_tdata,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    // cell_index
    output logic [nci_pkg::INDEX_W-1:0]                     m_tdata,
    output logic                                            m_tlast,
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    input  logic                                            cfg_valid,
    output logic                                            cfg_ready,
    input  logic [nci_pkg::CFG_IDX_W-1:0]                   cfg_index,
    input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] cfg_data
);
    import nci_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int CW = $clog2(MAX_CELLS_PER_AXIS);
    localparam int NW = $clog2(MAX_CELLS_PER_AXIS + 1);

    logic [2:0][W-1:0]          origin_reg;
    logic [CELL_SIZE_W-1:0]     cell_size_reg;
    logic [2:0][CELL_CNT_W-1:0] cells_reg;
    logic [INDEX_W-1:0]         nxy_reg;

    logic [2:0][W-1:0]          pos;
    logic [2:0][NW-1:0]         ncell;
    logic [2:0][CW-1:0]         lim;
    logic [2:0][CW-1:0]         fe_coord, be_coord;
    logic                       fe_valid, fe_ready, be_valid, be_ready;

    assign cfg_ready = 1'b1;

    // Unpack position fields
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            pos[a] = s_tdata[a*W +: W];
        end
    end

    // Effective cell counts: zero means one, saturate at the grid limit
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (cells_reg[a] == '0) begin
                ncell[a] = NW'(1);
            end else if (32'(cells_reg[a]) > MAX_CELLS_PER_AXIS) begin
                ncell[a] = NW'(MAX_CELLS_PER_AXIS);
            end else begin
                ncell[a] = NW'(cells_reg[a]);
            end
            lim[a] = CW'(ncell[a] - NW'(1));
        end
    end

    // Register writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg    <= '0;
            cell_size_reg <= CELL_SIZE_RST;
            cells_reg     <= {3{CELL_CNT_RST}};
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:  origin_reg[0]  <= cfg_data[W-1:0];
                REG_ORIGIN_Y:  origin_reg[1]  <= cfg_data[W-1:0];
                REG_ORIGIN_Z:  origin_reg[2]  <= cfg_data[W-1:0];
                REG_CELL_SIZE: cell_size_reg  <= cfg_data[CELL_SIZE_W-1:0];
                REG_CELLS_X:   cells_reg[0]   <= cfg_data[CELL_CNT_W-1:0];
                REG_CELLS_Y:   cells_reg[1]   <= cfg_data[CELL_CNT_W-1:0];
                REG_CELLS_Z:   cells_reg[2]   <= cfg_data[CELL_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Layer stride, follows the count registers
    always_ff @(posedge aclk) begin
        nxy_reg <= INDEX_W'(ncell[0]) * INDEX_W'(ncell[1]);
    end

    nci_front #(
        .COORD_WIDTH        (COORD_WIDTH),
        .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .pos       (pos),
        .origin    (origin_reg),
        .cell_size (cell_size_reg),
        .lim       (lim),
        .out_valid (fe_valid),
        .out_ready (fe_ready),
        .coord     (fe_coord)
    );

    nci_fifo #(
        .WIDTH (3*CW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_data   (fe_coord),
        .out_valid (be_valid),
        .out_ready (be_ready),
        .out_data  (be_coord)
    );

    nci_back #(
        .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (be_valid),
        .in_ready (be_ready),
        .coord    (be_coord),
        .lim      (lim),
        .nx       (ncell[0]),
        .nxy      (nxy_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: bench/neighbor_cell_index_gen_tb.sv
`timescale 1ns / 1ps

module neighbor_cell_index_gen_tb;
    import nci_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam logic [31:0] POS_MIN = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    // Expected cell indices for accepted positions, oldest first
    class cell_scoreboard;
        logic signed [31:0]     org_x, org_y, org_z;
        logic [CELL_SIZE_W-1:0] cell_sz;
        logic [CELL_CNT_W-1:0]  cnt_x, cnt_y, cnt_z;
        logic [INDEX_W-1:0]     index_q[$];
        logic                   last_q[$];
        int                     errors;

        function new();
            org_x   = '0;
            org_y   = '0;
            org_z   = '0;
            cell_sz = CELL_SIZE_RST;
            cnt_x   = CELL_CNT_RST;
            cnt_y   = CELL_CNT_RST;
            cnt_z   = CELL_CNT_RST;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                REG_ORIGIN_X:  org_x = d;
                REG_ORIGIN_Y:  org_y = d;
                REG_ORIGIN_Z:  org_z = d;
                REG_CELL_SIZE: cell_sz = d[CELL_SIZE_W-1:0];
                REG_CELLS_X:   cnt_x = d[CELL_CNT_W-1:0];
                REG_CELLS_Y:   cnt_y = d[CELL_CNT_W-1:0];
                REG_CELLS_Z:   cnt_z = d[CELL_CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int grid_cells(logic [CELL_CNT_W-1:0] n);
            if (n == 0) return 1;
            if (n > MAX_CELLS_DEF) return MAX_CELLS_DEF;
            return int'(n);
        endfunction

        // Truncate (pos - origin) / cell_size, clamp to the grid
        function int home_coord(logic signed [31:0] p, logic signed [31:0] o, int n);
            longint cs;
            longint q;
            cs = (cell_sz == 0) ? 64'd1 : longint'(cell_sz);
            if (p <= o) return 0;
            q = (longint'(p) - longint'(o)) / cs;
            return (q > n - 1) ? n - 1 : int'(q);
        endfunction

        function void note_position(logic signed [31:0] px, logic signed [31:0] py,
                                    logic signed [31:0] pz);
            int     step_x[9] = '{0, -1, -1, -1, 1, 1, 1, 0, 0};
            int     step_y[9] = '{0, 0, -1, 1, 0, -1, 1, -1, 1};
            int     step_z[3] = '{0, -1, 1};
            int     nx, ny, nz, cx, cy, cz, x, y, z;
            longint idx;
            nx = grid_cells(cnt_x);
            ny = grid_cells(cnt_y);
            nz = grid_cells(cnt_z);
            cx = home_coord(px, org_x, nx);
            cy = home_coord(py, org_y, ny);
            cz = home_coord(pz, org_z, nz);
            // Walk layers own, lower, upper; skip cells off the grid
            for (int l = 0; l < 3; l++) begin
                z = cz + step_z[l];
                if (z < 0 || z >= nz) continue;
                for (int k = 0; k < 9; k++) begin
                    x = cx + step_x[k];
                    y = cy + step_y[k];
                    if (x < 0 || x >= nx || y < 0 || y >= ny) continue;
                    idx = longint'(x) + longint'(nx) * y + longint'(nx) * ny * z;
                    index_q = {index_q, idx[INDEX_W-1:0]};
                    last_q  = {last_q, 1'b0};
                end
            end
            // The home cell is always in the grid, so the list is never empty
            last_q[last_q.size()-1] = 1'b1;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("MISMATCH: %s", msg);
        endfunction

        function void check_index(logic [INDEX_W-1:0] idx, logic last);
            logic [INDEX_W-1:0] want_idx;
            logic               want_last;
            if (index_q.size() == 0) begin
                report($sformatf("unexpected index %0d last %0b at %0t", idx, last, $realtime));
            end else begin
                want_idx  = index_q.pop_front();
                want_last = last_q.pop_front();
                if (want_idx !== idx || want_last !== last)
                    report($sformatf("expected index %0d last %0b, got index %0d last %0b at %0t",
                                     want_idx, want_last, idx, last, $realtime));
            end
        endfunction

        function int pending();
            return index_q.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [95:0]           s_tdata   = '0;   // pos_x, pos_y, pos_z from bit 0 up
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [INDEX_W-1:0]    m_tdata;          // cell_index
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [31:0]           cfg_data  = '0;

    bit                    tx_idle_on = 1'b1;
    bit                    rx_idle_on = 1'b1;

    // Stimulus-side view of the grid, used to aim positions at cells
    longint                grid_org[3];
    longint                grid_cs;
    int                    grid_n[3];

    cell_scoreboard sb = new();

    neighbor_cell_index_gen DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Observe every transaction at the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sb.note_position(s_tdata[31:0], s_tdata[63:32],
                                                       s_tdata[95:64]);
            if (m_tvalid && m_tready) sb.check_index(m_tdata, m_tlast);
        end
    end

    // Stall the result side in random bursts
    initial begin
        forever begin
            if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Hold one register write until it is taken; valid stays high for the next
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    function automatic int clip_cells(logic [31:0] d);
        if (d[8:0] == 0) return 1;
        if (d[8:0] > MAX_CELLS_DEF) return MAX_CELLS_DEF;
        return int'(d[8:0]);
    endfunction

    task automatic program_grid(input logic [31:0] ox, input logic [31:0] oy,
                                input logic [31:0] oz, input logic [31:0] cs,
                                input logic [31:0] nx, input logic [31:0] ny,
                                input logic [31:0] nz);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_CELL_SIZE, cs);
        write_reg(REG_CELLS_X, nx);
        write_reg(REG_CELLS_Y, ny);
        write_reg(REG_CELLS_Z, nz);
        if ($urandom_range(0, 1)) write_reg(REG_NONE, $urandom);
        cfg_valid <= 1'b0;
        grid_org[0] = longint'(signed'(ox));
        grid_org[1] = longint'(signed'(oy));
        grid_org[2] = longint'(signed'(oz));
        grid_cs     = (cs[30:0] == 0) ? 64'd1 : longint'(cs[30:0]);
        grid_n[0]   = clip_cells(nx);
        grid_n[1]   = clip_cells(ny);
        grid_n[2]   = clip_cells(nz);
    endtask

    // Present one position; valid stays high unless a gap is inserted
    task automatic send_pos(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tdata  <= {pz, py, px};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid, let the last transaction be noted, then wait until every
    // expected index has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    // Aim at a cell on one axis, edges favored, with a random fraction inside it
    function automatic logic [31:0] axis_pos(int a);
        longint c;
        longint p;
        case ($urandom_range(0, 5))
            0:       c = 0;
            1:       c = grid_n[a] - 1;
            default: c = $urandom_range(0, grid_n[a] - 1);
        endcase
        p = grid_org[a] + c * grid_cs + ($urandom % grid_cs);
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        return p[31:0];
    endfunction

    function automatic logic [31:0] rand_cells(bit wild);
        logic [8:0] n;
        case ($urandom_range(0, wild ? 7 : 5))
            0:       n = $urandom_range(1, 256);
            1:       n = (MAX_CELLS_DEF);
            6:       n = 0;
            7:       n = $urandom_range(257, 511);
            default: n = $urandom_range(1, 8);
        endcase
        // Bits above the register width are ignored
        return ($urandom & 32'hFFFF_FE00) | 32'(n);
    endfunction

    task automatic rand_grid(input bit wild);
        logic [31:0] o[3];
        logic [31:0] cs;
        for (int a = 0; a < 3; a++)
            o[a] = ($urandom_range(0, 3) == 0) ? $urandom
                                              : 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
        case ($urandom_range(0, 3))
            0:       cs = $urandom;
            1:       cs = ONE_Q16;
            default: cs = $urandom_range(1, 1 << $urandom_range(4, 20));
        endcase
        program_grid(o[0], o[1], o[2], cs, rand_cells(wild), rand_cells(wild),
                     rand_cells(wild));
    endtask

    task automatic rand_items(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 5) == 0)
                send_pos($urandom, $urandom, $urandom);
            else
                send_pos(axis_pos(0), axis_pos(1), axis_pos(2));
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Default grid: 16 cells of 1.0 from the origin
        grid_org = '{0, 0, 0};
        grid_cs  = 65536;
        grid_n   = '{16, 16, 16};
        send_pos(32'h0, 32'h0, 32'h0);
        send_pos(32'h000F_8000, 32'h000F_8000, 32'h000F_8000);
        send_pos(32'h0008_0000, 32'h0008_0000, 32'h0008_0000);
        send_pos(POS_MIN, POS_MIN, POS_MIN);
        send_pos(POS_MAX, POS_MAX, POS_MAX);
        send_pos(POS_MIN, POS_MAX, 32'h0005_0000);
        send_pos(32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_FFFF);
        send_pos(32'h0000_0001, 32'h0010_0000, 32'h000E_FFFF);
        send_pos(32'h0003_4000, 32'h0000_0000, 32'h000F_0000);
        send_pos(32'hFFFF_0000, 32'h0007_8000, 32'h0001_0001);
        drain();

        // Single-cell grid, zero cell size treated as one step
        program_grid(POS_MIN, POS_MIN, POS_MIN, 32'h0, 32'h1, 32'h1, 32'h1);
        send_pos(POS_MIN, POS_MIN, POS_MIN);
        send_pos(POS_MAX, POS_MAX, POS_MAX);
        send_pos(32'h0, 32'h1234_5678, 32'hDEAD_BEEF);
        drain();

        // Widest grid, smallest step; zero and oversized counts on two axes
        program_grid(POS_MAX, POS_MIN, 32'h0, 32'h1, 32'h0, 32'h1FF, 32'h100);
        send_pos(POS_MAX, POS_MIN, 32'h0);
        send_pos(POS_MIN, POS_MAX, POS_MAX);
        send_pos(32'h0, POS_MIN + 32'd200, 32'd100);
        send_pos(32'h0, POS_MIN + 32'd255, 32'd254);
        send_pos(32'h0, POS_MIN + 32'd1, 32'd1);
        drain();

        // Largest cell size, ignored upper data bits
        program_grid(32'hFFFF_0000, 32'h0, POS_MIN, 32'hFFFF_FFFF, 32'hFFFF_FE03,
                     32'h2, 32'h100);
        send_pos(POS_MAX, POS_MAX, POS_MAX);
        send_pos(32'h0, 32'h0, 32'h0);
        drain();

        // Random grids and positions, the last phase without idling
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            rand_grid(ph[0]);
            rand_items(33);
        end

        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
